>>> src/base64_stream_encoder_macros.svh
// assertion macros shared by the base64 encoder modules
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/b64e_pkg.sv
// shared types, constants and alphabet lookup for the base64 encoder
package b64e_pkg;

    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 7'd43;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 7'd47;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 7'd61;

    // position of the next byte within its three-byte group
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    // one unit of work: the characters a byte produces
    typedef struct packed {
        logic [3:0][CHAR_W-1:0] chars;
        logic [1:0]             last_idx;
        logic                   fin;
    } entry_t;

    // sextet to standard alphabet character
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] six);
        logic [CHAR_W-1:0] s;
        s = {1'b0, six};
        if (six < 6'd26) begin
            return s + CHAR_UPPER_A;
        end else if (six < 6'd52) begin
            return s - 7'd26 + CHAR_LOWER_A;
        end else if (six < 6'd62) begin
            return s - 7'd52 + CHAR_DIGIT_0;
        end else if (six == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

>>> src/b64e_front.sv
// input side: tracks group position and carry bits, builds one entry per byte
`include "base64_stream_encoder_macros.svh"

module b64e_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tlast,   // final_byte
    input  logic             q_full,
    output logic             push,
    output b64e_pkg::entry_t push_entry
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       carry_reg, carry_next;
    logic             s_accept;
    logic [7:0]       b;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;
    assign push     = s_accept;
    assign b        = s_tdata;

    // characters for this byte and the state it leaves behind
    always_comb begin
        push_entry = '0;
        push_entry.fin = s_tlast;
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            b64e_pkg::PH_SECOND: begin
                push_entry.chars[0] = b64e_pkg::sextet_char({carry_reg[1:0], b[7:4]});
                if (s_tlast) begin
                    push_entry.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
                    push_entry.chars[2] = b64e_pkg::CHAR_PAD;
                    push_entry.last_idx = 2'd2;
                end
                carry_next = b[3:0];
                phase_next = b64e_pkg::PH_THIRD;
            end
            b64e_pkg::PH_THIRD: begin
                push_entry.chars[0] = b64e_pkg::sextet_char({carry_reg, b[7:6]});
                push_entry.chars[1] = b64e_pkg::sextet_char(b[5:0]);
                push_entry.last_idx = 2'd1;
                carry_next = 4'd0;
                phase_next = b64e_pkg::PH_FIRST;
            end
            default: begin
                push_entry.chars[0] = b64e_pkg::sextet_char(b[7:2]);
                if (s_tlast) begin
                    push_entry.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
                    push_entry.chars[2] = b64e_pkg::CHAR_PAD;
                    push_entry.chars[3] = b64e_pkg::CHAR_PAD;
                    push_entry.last_idx = 2'd3;
                end
                carry_next = {2'b00, b[1:0]};
                phase_next = b64e_pkg::PH_SECOND;
            end
        endcase
        if (s_tlast) begin
            carry_next = 4'd0;
            phase_next = b64e_pkg::PH_FIRST;
        end
    end

    // group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PH_FIRST;
            carry_reg <= 4'd0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    `B64E_ASSERT_NEXT(a_final_restarts, s_accept && s_tlast, phase_reg == b64e_pkg::PH_FIRST && carry_reg == 4'd0, "group state not cleared after final item")

endmodule

>>> src/b64e_queue.sv
// short entry queue between the front and back parts
`include "base64_stream_encoder_macros.svh"

module b64e_queue #(
    parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b64e_pkg::entry_t push_entry,
    output logic             q_full,
    input  logic             pop,
    output logic             q_valid,
    output b64e_pkg::entry_t q_entry
);

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

    b64e_pkg::entry_t  slots_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = (count_reg == CntFull);
    assign q_valid = (count_reg != '0);
    assign q_entry = slots_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `B64E_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CntFull, "queue fill count beyond depth")
    `B64E_ASSERT_NEXT(a_count_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue fill count did not grow on push")

endmodule

>>> src/b64e_back.sv
// output side: head entry to output register, one character per cycle unless stalled
`include "base64_stream_encoder_macros.svh"

module b64e_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  b64e_pkg::entry_t q_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [6:0] out_char, [7] zero
    output logic             m_tlast    // last_char
);

    logic [1:0]                  idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [b64e_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_last_reg;
    logic                        load, at_end;

    assign load   = q_valid && (!out_valid_reg || m_tready);
    assign at_end = (idx_reg == q_entry.last_idx);
    assign pop    = load && at_end;

    // character index and output valid
    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_char_reg <= q_entry.chars[idx_reg];
            out_last_reg <= q_entry.fin && at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    `B64E_ASSERT_NOW(a_entry_held, idx_reg != 2'd0, q_valid, "partly sent entry left the queue")

endmodule

>>> src/base64_stream_encoder.sv
// top level of the base64 stream encoder
//
// Takes raw bytes on the s_ channel (s_tdata[7:0] a byte, s_tlast on the
// last byte of a message) and sends standard-alphabet Base64 characters on
// the m_ channel (m_tdata[6:0] the ASCII code, m_tlast on the last
// character of the message, '=' padding included).
// A byte yields one or two characters inside a group and two to four on
// the final byte; an empty message yields nothing.
// With the queue empty, the first character of a byte passes through the
// entry queue and then the output register before m_tvalid rises.
// Throughput: one character per cycle while m_tready is high, set by the
// single output register that the back part fills from the head of the
// entry queue.
// The front keeps taking bytes while the queue has room, so it runs ahead
// of a stalled receiver by QueueDepth entries; m_tvalid and the payload
// hold while m_tready is low.
// Reset (aresetn low, synchronous) empties the queue, drops any
// undelivered character and restarts at the beginning of a group.
module base64_stream_encoder #(
    parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast    // last_char
);

    b64e_pkg::entry_t push_entry;
    b64e_pkg::entry_t q_entry;
    logic             push, pop, q_full, q_valid;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> test/tb_base64_stream_encoder.sv
// testbench for the base64 stream encoder: byte messages in, checked character stream out
module tb_base64_stream_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_OFF_LEN  = 150;
    localparam int IDLE_PCT      = 6;
    localparam int RANDOM_ITEMS  = 313;

    // standard alphabet, index 0 in the top byte
    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // position of the next byte within its three-byte group
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2,
        GRP_UNUSED = 2'd3
    } grp_pos_t;

    typedef struct packed {
        logic [b64e_pkg::CHAR_W-1:0] code;
        logic                        is_last;
    } b64_char_t;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tlast;   // final_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [6:0] out_char, [7] zero
    logic       m_tlast;   // last_char

    // encoder state as predicted
    grp_pos_t    enc_pos;
    logic [3:0]  enc_carry;
    b64_char_t   pending_chars[$];

    int          n_errors;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;

    base64_stream_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        aclk = 1'b0;
        #(CLK_HALF);
        aclk = 1'b1;
        #(CLK_HALF);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("base64_stream_encoder verification failed");
            $finish;
        end
    end

    function automatic void push_char(input logic [5:0] six, input logic is_last);
        b64_char_t c;
        c.code    = B64_ALPHABET[six][b64e_pkg::CHAR_W-1:0];
        c.is_last = is_last;
        pending_chars.push_back(c);
    endfunction

    function automatic void push_pad(input logic is_last);
        b64_char_t c;
        c.code    = b64e_pkg::CHAR_PAD;
        c.is_last = is_last;
        pending_chars.push_back(c);
    endfunction

    // characters one accepted byte yields, and the state it leaves
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (enc_pos)
            GRP_SECOND: begin
                push_char({enc_carry[1:0], b[7:4]}, 1'b0);
                enc_carry = b[3:0];
                if (fin) begin
                    push_char({enc_carry, 2'b00}, 1'b0);
                    push_pad(1'b1);
                end
                enc_pos = GRP_THIRD;
            end
            GRP_THIRD: begin
                push_char({enc_carry, b[7:6]}, 1'b0);
                push_char(b[5:0], fin);
                enc_carry = 4'd0;
                enc_pos   = GRP_FIRST;
            end
            default: begin
                // first byte of a group; the unused position behaves the same
                push_char(b[7:2], 1'b0);
                enc_carry = {2'b00, b[1:0]};
                if (fin) begin
                    push_char({enc_carry[1:0], 4'b0000}, 1'b0);
                    push_pad(1'b0);
                    push_pad(1'b1);
                end
                enc_pos = GRP_SECOND;
            end
        endcase
        if (fin) begin
            enc_pos   = GRP_FIRST;
            enc_carry = 4'd0;
        end
    endfunction

    // both channels: predict on each accepted byte, then check each character
    always @(posedge aclk) begin
        b64_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected char, expected none, actual 0x%02h last %0b",
                             $time, m_tdata, m_tlast);
                    n_errors++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_tdata !== {1'b0, want.code}) begin
                        $display("%0t: char mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, {1'b0, want.code}, m_tdata);
                        n_errors++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $display("%0t: last flag mismatch, expected %0b, actual %0b",
                                 $time, want.is_last, m_tlast);
                        n_errors++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one item and wait for it to be taken; called at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_message(input byte_q_t msg);
        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // random byte, weighted toward the extremes
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // extremes, every group position as the final byte, '+' and '/'
    task automatic test_directed_messages();
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h00, 8'hFF});
        send_message('{8'hFF, 8'h00});
        send_message('{8'h4D, 8'h61, 8'h6E});
        send_message('{8'hFB, 8'hFF, 8'hBF});
        send_message('{8'h00, 8'h00, 8'h00, 8'h00});
        send_message('{8'hFC, 8'h0F, 8'hC0, 8'hFF, 8'h01});
        wait_drained();
    endtask

    // back-to-back items with a receiver that never stalls
    task automatic test_steady_stream();
        int sent;
        int len;
        idle_pct  = 0;
        stall_pct = 0;
        sent = 0;
        while (sent < 30) begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
                send_byte(pick_byte(), i == len - 1);
            end
            sent += len;
        end
        wait_drained();
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    // receiver holds off while bytes keep coming, so the input stalls
    task automatic test_output_hold_off();
        byte_q_t msg;
        hold_left = HOLD_OFF_LEN;
        for (int i = 0; i < 16; i++) begin
            msg.push_back(pick_byte());
        end
        send_message(msg);
        wait_drained();
    endtask

    // random messages, mostly short, a few long
    task automatic test_random_messages();
        int sent;
        int len;
        int sel;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(19);
            if (sel < 14) len = $urandom_range(1, 6);
            else if (sel < 19) len = $urandom_range(7, 20);
            else len = $urandom_range(21, 48);
            for (int i = 0; i < len; i++) begin
                send_byte(pick_byte(), i == len - 1);
            end
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        enc_pos     = GRP_FIRST;
        enc_carry   = 4'd0;
        n_errors    = 0;
        cycle_count = 0;
        idle_pct    = IDLE_PCT;
        stall_pct   = IDLE_PCT;
        hold_left   = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_messages();
        test_steady_stream();
        test_output_hold_off();
        test_random_messages();

        if (n_errors == 0) begin
            $display("base64_stream_encoder verification clean");
        end else begin
            $display("base64_stream_encoder verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
test/tb_base64_stream_encoder.sv
